>>> src/vector_cartesian_polar_unit_macros.svh
// Assertion macros shared by the vector unit RTL.
`ifndef VECTOR_CARTESIAN_POLAR_UNIT_MACROS_SVH
`define VECTOR_CARTESIAN_POLAR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VCPU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vector unit assertion failed");

// Next-cycle implication, checked outside reset.
`define VCPU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vector unit assertion failed");

`endif

>>> src/vcpu_pkg.sv
// Types, constants and helper functions for the vector unit.
package vcpu_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int IN_DATA_W     = 216;
  localparam int IN_USER_W     = 2;
  localparam int OUT_DATA_W    = 120;
  localparam int CORDIC_ITER   = 30;
  localparam int ITER_IDX_W    = $clog2(CORDIC_ITER);
  localparam int DEG_FULL      = 360;
  localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;

  typedef enum logic [1:0] {
    FUNC_XY    = 2'd0,
    FUNC_POLAR = 2'd1,
    FUNC_ADD   = 2'd2,
    FUNC_SCALE = 2'd3
  } func_e;

  typedef struct packed {
    func_e              func;
    logic signed [31:0] xs;
    logic signed [31:0] ys;
  } sel_t;

  typedef struct packed {
    sel_t        sel;
    logic [46:0] x0;
    logic        dneg;
  } div_side_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } xy_t;

  typedef struct packed {
    xy_t                v;
    logic signed [24:0] dir;
  } res_t;

  // Arctangent of 2^-i in binary turns, 2^32 being a full circle.
  function automatic logic [31:0] atan_turn(input logic [ITER_IDX_W-1:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = signed'(v[31:0]);
    end
    return r;
  endfunction

endpackage

>>> src/vcpu_cordic.sv
// Pipelined CORDIC, one iteration per register stage, rotation or vectoring.
module vcpu_cordic #(
  parameter int  XW        = 50,
  parameter int  ZW        = 34,
  parameter bit  VECTORING = 1'b0,
  parameter type side_t    = logic
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  side_t                side_i,
  output logic                 vld_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output side_t                side_o
);
  import vcpu_pkg::*;

  logic                 vld_q  [CORDIC_ITER];
  logic signed [XW-1:0] x_q    [CORDIC_ITER];
  logic signed [XW-1:0] y_q    [CORDIC_ITER];
  logic signed [ZW-1:0] z_q    [CORDIC_ITER];
  side_t                side_q [CORDIC_ITER];

  for (genvar k = 0; k < CORDIC_ITER; k++) begin : g_iter
    logic                 vin;
    logic signed [XW-1:0] xin;
    logic signed [XW-1:0] yin;
    logic signed [ZW-1:0] zin;
    side_t                sin;
    logic signed [XW-1:0] xsh;
    logic signed [XW-1:0] ysh;
    logic signed [ZW-1:0] ang;
    logic                 cw;

    if (k == 0) begin : g_head
      assign vin = vld_i;
      assign xin = x_i;
      assign yin = y_i;
      assign zin = z_i;
      assign sin = side_i;
    end else begin : g_body
      assign vin = vld_q[k-1];
      assign xin = x_q[k-1];
      assign yin = y_q[k-1];
      assign zin = z_q[k-1];
      assign sin = side_q[k-1];
    end

    assign xsh = xin >>> k;
    assign ysh = yin >>> k;
    assign ang = ZW'(atan_turn(ITER_IDX_W'(k)));

    // Vectoring drives y to zero, rotation drives the residual angle to zero.
    if (VECTORING) begin : g_vec
      assign cw = !yin[XW-1] && (yin != '0);
    end else begin : g_rot
      assign cw = zin[ZW-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= sin;
        if (cw) begin
          x_q[k] <= xin + ysh;
          y_q[k] <= yin - xsh;
          z_q[k] <= zin + ang;
        end else begin
          x_q[k] <= xin - ysh;
          y_q[k] <= yin + xsh;
          z_q[k] <= zin - ang;
        end
      end
    end
  end

  assign vld_o  = vld_q[CORDIC_ITER-1];
  assign x_o    = x_q[CORDIC_ITER-1];
  assign y_o    = y_q[CORDIC_ITER-1];
  assign z_o    = z_q[CORDIC_ITER-1];
  assign side_o = side_q[CORDIC_ITER-1];

endmodule

>>> src/vcpu_isqrt.sv
// Pipelined integer square root of a 64-bit word, one root bit per stage.
module vcpu_isqrt #(
  parameter type side_t = logic
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  logic [63:0] s_i,
  input  side_t       side_i,
  output logic        vld_o,
  output logic [31:0] root_o,
  output logic [33:0] rem_o,
  output side_t       side_o
);
  localparam int STAGES = 32;

  logic        vld_q  [STAGES];
  logic [63:0] s_q    [STAGES];
  logic [31:0] root_q [STAGES];
  logic [33:0] rem_q  [STAGES];
  side_t       side_q [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_digit
    logic        vin;
    logic [63:0] sin;
    logic [31:0] rin;
    logic [33:0] min;
    side_t       din;
    logic [33:0] part;
    logic [33:0] trial;

    if (k == 0) begin : g_head
      assign vin = vld_i;
      assign sin = s_i;
      assign rin = '0;
      assign min = '0;
      assign din = side_i;
    end else begin : g_body
      assign vin = vld_q[k-1];
      assign sin = s_q[k-1];
      assign rin = root_q[k-1];
      assign min = rem_q[k-1];
      assign din = side_q[k-1];
    end

    // Before the last digit the remainder stays below 2^32.
    assign part  = {min[31:0], sin[63:62]};
    assign trial = {rin, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= din;
        s_q[k]    <= {sin[61:0], 2'b00};
        if (part >= trial) begin
          rem_q[k]  <= part - trial;
          root_q[k] <= {rin[30:0], 1'b1};
        end else begin
          rem_q[k]  <= part;
          root_q[k] <= {rin[30:0], 1'b0};
        end
      end
    end
  end

  assign vld_o  = vld_q[STAGES-1];
  assign root_o = root_q[STAGES-1];
  assign rem_o  = rem_q[STAGES-1];
  assign side_o = side_q[STAGES-1];

endmodule

>>> src/vector_cartesian_polar_unit.sv
// Accepts one beat per cycle while the skid register is empty; every CORDIC iteration and
// square-root digit owns one register stage, and the degrees-to-turns conversion takes
// three stages of reciprocal arithmetic. An output register and a skid register let a new
// beat in while a result waits.
// Reset (asynchronous, active low) clears all valid bits; payload is not reset.
module vector_cartesian_polar_unit #(
  parameter int FRAC_BITS = vcpu_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // x_a, y_a, x_b, y_b, magnitude_in, direction_in, scale_factor
  input  logic [vcpu_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // func
  input  logic [vcpu_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // x_out, y_out, magnitude_out, direction_out
  output logic [vcpu_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import vcpu_pkg::*;

  localparam int SHL    = 32 - FRAC_BITS;
  localparam int SH3    = SHL - 3;
  localparam int ROT_XW = 50;
  localparam int ROT_ZW = 34;
  localparam int VEC_XW = 63;
  localparam int VEC_ZW = 33;
  localparam int DW     = 44;

  localparam logic signed [63:0]     SCL_HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [ROT_ZW-1:0] ROT_Q  = ROT_ZW'(1) << 30;
  localparam logic signed [VEC_ZW-1:0] VEC_Q  = VEC_ZW'(1) << 30;
  localparam logic signed [DW-1:0]   HALF     = DW'(180) << FRAC_BITS;
  localparam logic signed [DW-1:0]   NINETY   = DW'(90) << FRAC_BITS;
  localparam logic signed [DW-1:0]   RND      = DW'(1) << (31 - FRAC_BITS);
  localparam logic signed [DW-1:0]   ZM_C     = DW'(DEG_FULL);
  localparam logic signed [DW-1:0]   DIR_MAX  = DW'(2**24 - 1);
  localparam logic signed [DW-1:0]   DIR_MIN  = DW'(-(2**24));
  // Ceiling of 2^31 / 45; exact quotient for any 25-bit dividend.
  localparam logic [25:0]            RECIP45  = 26'd47721859;

  logic adv;
  logic o_vld_q, k_vld_q;
  logic [OUT_DATA_W-1:0] o_data_q, k_data_q;

  assign adv           = !k_vld_q;
  assign s_axis_tready = adv;

  // Input register.
  logic               f1_vld_q;
  func_e              f1_func_q;
  logic signed [31:0] f1_xa_q, f1_ya_q, f1_xb_q, f1_yb_q, f1_scl_q;
  logic [30:0]        f1_mag_q;
  logic signed [24:0] f1_dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
    end else if (adv) begin
      f1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_func_q <= func_e'(s_axis_tuser);
      f1_xa_q   <= signed'(s_axis_tdata[31:0]);
      f1_ya_q   <= signed'(s_axis_tdata[63:32]);
      f1_xb_q   <= signed'(s_axis_tdata[95:64]);
      f1_yb_q   <= signed'(s_axis_tdata[127:96]);
      f1_mag_q  <= s_axis_tdata[158:128];
      f1_dir_q  <= signed'(s_axis_tdata[183:159]);
      f1_scl_q  <= signed'(s_axis_tdata[215:184]);
    end
  end

  // Products, sums and the absolute direction.
  logic               f2_vld_q;
  func_e              f2_func_q;
  logic signed [31:0] f2_xa_q, f2_ya_q;
  logic signed [63:0] f2_px_q, f2_py_q;
  logic signed [32:0] f2_sx_q, f2_sy_q;
  logic [62:0]        f2_pm_q;
  logic [24:0]        f2_dabs_q;
  logic               f2_dneg_q;
  logic [24:0]        d_abs;

  assign d_abs = f1_dir_q[24] ? 25'(-f1_dir_q) : 25'(f1_dir_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_vld_q <= 1'b0;
    end else if (adv) begin
      f2_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f2_func_q <= f1_func_q;
      f2_xa_q   <= f1_xa_q;
      f2_ya_q   <= f1_ya_q;
      f2_px_q   <= 64'(f1_xa_q) * 64'(f1_scl_q);
      f2_py_q   <= 64'(f1_ya_q) * 64'(f1_scl_q);
      f2_sx_q   <= 33'(f1_xa_q) + 33'(f1_xb_q);
      f2_sy_q   <= 33'(f1_ya_q) + 33'(f1_yb_q);
      f2_pm_q   <= 63'(f1_mag_q) * 63'(INV_GAIN);
      f2_dabs_q <= d_abs;
      f2_dneg_q <= f1_dir_q[24];
    end
  end

  // Result selection for the cartesian operations, and the direction divided by 45.
  logic               f3_vld_q;
  div_side_t          f3_side_q;
  logic [19:0]        f3_u_q;
  logic [24:0]        f3_dabs_q;
  logic signed [63:0] scl_x, scl_y;
  logic [50:0]        u_prod;
  sel_t               f3_sel;

  assign scl_x  = (f2_px_q + SCL_HALF) >>> FRAC_BITS;
  assign scl_y  = (f2_py_q + SCL_HALF) >>> FRAC_BITS;
  assign u_prod = 51'(f2_dabs_q) * 51'(RECIP45);

  always_comb begin
    f3_sel.func = f2_func_q;
    case (f2_func_q)
      FUNC_XY: begin
        f3_sel.xs = f2_xa_q;
        f3_sel.ys = f2_ya_q;
      end
      FUNC_ADD: begin
        f3_sel.xs = sat32(64'(f2_sx_q));
        f3_sel.ys = sat32(64'(f2_sy_q));
      end
      FUNC_SCALE: begin
        f3_sel.xs = sat32(scl_x);
        f3_sel.ys = sat32(scl_y);
      end
      default: begin
        f3_sel.xs = '0;
        f3_sel.ys = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f3_vld_q <= 1'b0;
    end else if (adv) begin
      f3_vld_q <= f2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f3_side_q.sel  <= f3_sel;
      // Drop the sixteen guard bits of the gain product.
      f3_side_q.x0   <= f2_pm_q[62:16];
      f3_side_q.dneg <= f2_dneg_q;
      f3_u_q         <= u_prod[50:31];
      f3_dabs_q      <= f2_dabs_q;
    end
  end

  // Degrees to turns is round(|d| * 2^SHL / 360). With |d| = 45u + w and
  // w * 2^(SHL-3) = 45k + r, the quotient is u * 2^(SHL-3) + k, plus one when r
  // reaches 23. The table below holds k and r for every w.
  logic [31:0] frac_k [45];
  logic [5:0]  frac_r [45];

  for (genvar j = 0; j < 45; j++) begin : g_tab
    assign frac_k[j] = 32'((j << SH3) / 45);
    assign frac_r[j] = 6'((j << SH3) % 45);
  end

  logic        f4_vld_q;
  logic [19:0] f4_u_q;
  logic [5:0]  f4_w_q;
  div_side_t   f4_side_q;
  logic [24:0] w_full;

  assign w_full = f3_dabs_q - 25'(f3_u_q) * 25'd45;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f4_vld_q <= 1'b0;
    end else if (adv) begin
      f4_vld_q <= f3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f4_u_q    <= f3_u_q;
      f4_w_q    <= w_full[5:0];
      f4_side_q <= f3_side_q;
    end
  end

  logic        f5_vld_q;
  logic [31:0] f5_k_q;
  div_side_t   f5_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f5_vld_q <= 1'b0;
    end else if (adv) begin
      f5_vld_q <= f4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f5_k_q    <= (32'(f4_u_q) << SH3) + frac_k[f4_w_q] + 32'(frac_r[f4_w_q] >= 6'd23);
      f5_side_q <= f4_side_q;
    end
  end

  // Signed angle in turns, wrapped to 32 bits.
  logic               p_vld_q;
  logic signed [31:0] p_t_q;
  div_side_t          p_side_q;
  logic [31:0]        q_sgn;

  assign q_sgn = f5_side_q.dneg ? -f5_k_q : f5_k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (adv) begin
      p_vld_q <= f5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_t_q    <= signed'(q_sgn);
      p_side_q <= f5_side_q;
    end
  end

  // Quarter-turn pre-rotation for angles beyond a right angle.
  logic signed [ROT_XW-1:0] rot_x, rot_y, rot_x0;
  logic signed [ROT_ZW-1:0] rot_z, rot_tz;

  assign rot_tz = ROT_ZW'(p_t_q);
  assign rot_x0 = signed'({3'b000, p_side_q.x0});

  always_comb begin
    if (rot_tz > ROT_Q) begin
      rot_x = '0;
      rot_y = rot_x0;
      rot_z = rot_tz - ROT_Q;
    end else if (rot_tz < -ROT_Q) begin
      rot_x = '0;
      rot_y = -rot_x0;
      rot_z = rot_tz + ROT_Q;
    end else begin
      rot_x = rot_x0;
      rot_y = '0;
      rot_z = rot_tz;
    end
  end

  logic                     rc_vld;
  logic signed [ROT_XW-1:0] rc_x, rc_y;
  sel_t                     rc_side;

  vcpu_cordic #(
    .XW        (ROT_XW),
    .ZW        (ROT_ZW),
    .VECTORING (1'b0),
    .side_t    (sel_t)
  ) u_rot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (p_vld_q),
    .x_i    (rot_x),
    .y_i    (rot_y),
    .z_i    (rot_z),
    .side_i (p_side_q.sel),
    .vld_o  (rc_vld),
    .x_o    (rc_x),
    .y_o    (rc_y),
    .z_o    (),
    .side_o (rc_side)
  );

  // Final saturated x and y of the operation.
  logic                     g_vld_q;
  logic signed [31:0]       g_x_q, g_y_q;
  logic signed [ROT_XW-1:0] rnd_x, rnd_y;

  assign rnd_x = (rc_x + ROT_XW'(32768)) >>> 16;
  assign rnd_y = (rc_y + ROT_XW'(32768)) >>> 16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else if (adv) begin
      g_vld_q <= rc_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (rc_side.func == FUNC_POLAR) begin
        g_x_q <= sat32(64'(rnd_x));
        g_y_q <= sat32(64'(rnd_y));
      end else begin
        g_x_q <= rc_side.xs;
        g_y_q <= rc_side.ys;
      end
    end
  end

  // Move the vector into the right half plane, then widen for the vectoring pass.
  logic signed [32:0]       vx33, vy33, gx33, gy33;
  logic signed [VEC_XW-1:0] vec_x, vec_y;
  logic signed [VEC_ZW-1:0] vec_z;
  xy_t                      g_xy;

  assign gx33 = 33'(g_x_q);
  assign gy33 = 33'(g_y_q);

  always_comb begin
    if (g_x_q < 0) begin
      if (g_y_q > 0) begin
        vx33  = gy33;
        vy33  = -gx33;
        vec_z = VEC_Q;
      end else begin
        vx33  = -gy33;
        vy33  = gx33;
        vec_z = -VEC_Q;
      end
    end else begin
      vx33  = gx33;
      vy33  = gy33;
      vec_z = '0;
    end
    vec_x = VEC_XW'(vx33) <<< 28;
    vec_y = VEC_XW'(vy33) <<< 28;
  end

  assign g_xy.x = g_x_q;
  assign g_xy.y = g_y_q;

  logic                     vc_vld;
  logic signed [VEC_ZW-1:0] vc_z;
  xy_t                      vc_side;

  vcpu_cordic #(
    .XW        (VEC_XW),
    .ZW        (VEC_ZW),
    .VECTORING (1'b1),
    .side_t    (xy_t)
  ) u_vec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (g_vld_q),
    .x_i    (vec_x),
    .y_i    (vec_y),
    .z_i    (vec_z),
    .side_i (g_xy),
    .vld_o  (vc_vld),
    .x_o    (),
    .y_o    (),
    .z_o    (vc_z),
    .side_o (vc_side)
  );

  // Turns scaled to degrees, and the squares for the magnitude.
  logic                 h1_vld_q;
  logic signed [DW-1:0] h1_zm_q;
  logic signed [63:0]   h1_xx_q, h1_yy_q;
  xy_t                  h1_xy_q;
  logic signed [DW-1:0] vc_zw;

  assign vc_zw = DW'(vc_z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h1_vld_q <= 1'b0;
    end else if (adv) begin
      h1_vld_q <= vc_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h1_zm_q <= vc_zw * ZM_C + RND;
      h1_xx_q <= 64'(vc_side.x) * 64'(vc_side.x);
      h1_yy_q <= 64'(vc_side.y) * 64'(vc_side.y);
      h1_xy_q <= vc_side;
    end
  end

  // Direction clamps and the axis cases.
  logic                 h2_vld_q;
  logic [63:0]          h2_s_q;
  res_t                 h2_res_q;
  logic signed [DW-1:0] dir_w;

  always_comb begin
    dir_w = h1_zm_q >>> SHL;
    if (dir_w > HALF) begin
      dir_w = HALF;
    end else if (dir_w <= -HALF) begin
      dir_w = -HALF + DW'(1);
    end
    if (h1_xy_q.y == '0) begin
      dir_w = (h1_xy_q.x < 0) ? HALF : '0;
    end else if (h1_xy_q.x == '0) begin
      dir_w = (h1_xy_q.y > 0) ? NINETY : -NINETY;
    end
    if (dir_w > DIR_MAX) begin
      dir_w = DIR_MAX;
    end else if (dir_w < DIR_MIN) begin
      dir_w = DIR_MIN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h2_vld_q <= 1'b0;
    end else if (adv) begin
      h2_vld_q <= h1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h2_s_q       <= unsigned'(h1_xx_q) + unsigned'(h1_yy_q);
      h2_res_q.v   <= h1_xy_q;
      h2_res_q.dir <= dir_w[24:0];
    end
  end

  logic        sq_vld;
  logic [31:0] sq_root;
  logic [33:0] sq_rem;
  res_t        sq_side;

  vcpu_isqrt #(
    .side_t (res_t)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (h2_vld_q),
    .s_i    (h2_s_q),
    .side_i (h2_res_q),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .rem_o  (sq_rem),
    .side_o (sq_side)
  );

  // Round the root to nearest and saturate to the field.
  logic                  r_vld_q;
  logic [OUT_DATA_W-1:0] r_data_q;
  logic [32:0]           mag_r;
  logic [30:0]           mag_s;

  assign mag_r = {1'b0, sq_root} + 33'(sq_rem > {2'b00, sq_root});
  assign mag_s = (mag_r > 33'h07FFFFFFF) ? 31'h7FFFFFFF : mag_r[30:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
    end else if (adv) begin
      r_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_data_q <= {sq_side.dir, mag_s, sq_side.v.y, sq_side.v.x};
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
      k_vld_q <= 1'b0;
    end else if (adv) begin
      if (r_vld_q) begin
        if (!o_vld_q || m_axis_tready) begin
          o_vld_q <= 1'b1;
        end else begin
          k_vld_q <= 1'b1;
        end
      end else if (m_axis_tready) begin
        o_vld_q <= 1'b0;
      end
    end else if (m_axis_tready) begin
      o_vld_q <= 1'b1;
      k_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (r_vld_q) begin
        if (!o_vld_q || m_axis_tready) begin
          o_data_q <= r_data_q;
        end else begin
          k_data_q <= r_data_q;
        end
      end
    end else if (m_axis_tready) begin
      o_data_q <= k_data_q;
    end
  end

  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tdata  = o_data_q;

`include "vector_cartesian_polar_unit_macros.svh"

  `VCPU_ASSERT_NOW(a_skid_behind_out, k_vld_q, o_vld_q)
  `VCPU_ASSERT_NEXT(a_stall_fills_skid, o_vld_q && !m_axis_tready && !k_vld_q && r_vld_q, k_vld_q)
  `VCPU_ASSERT_NOW(a_zero_vector, o_vld_q && (o_data_q[63:0] == '0), o_data_q[119:64] == '0)

endmodule
